@@ rtl/core/hms_pkg.sv @@
// ----------------------------------------------------------------------------
// hms_pkg
// Shared widths, operation codes and types for the height map hill stamper.
// ----------------------------------------------------------------------------
package hms_pkg;

    localparam int OP_W       = 2;
    localparam int COORD_IN_W = 6;
    localparam int RADIUS_W   = 8;
    localparam int SQUARE_W   = 2 * RADIUS_W;
    localparam int HEIGHT_W   = 32;
    localparam int SCALED_W   = 13;
    localparam int SIDE_CFG_W = 7;

    // operation codes
    localparam logic [OP_W-1:0] OP_CLEAR = 2'd0;
    localparam logic [OP_W-1:0] OP_STAMP = 2'd1;
    localparam logic [OP_W-1:0] OP_READ  = 2'd2;

    localparam logic [SIDE_CFG_W-1:0] SIDE_CFG_RESET = 7'd64;
    localparam logic [HEIGHT_W-1:0]   MAX_HEIGHT     = 32'hFFFF_FFFF;
    localparam logic [SCALED_W-1:0]   SCALE_TOP      = 13'd5120;

    // quotient bits of the scale division, one per step
    localparam int DIV_STEPS  = SCALED_W;
    localparam int DIV_CNT_W  = 4;

    typedef struct packed {
        logic busy;
        logic done;
    } hms_div_status_t;

endpackage

@@ rtl/core/hms_item_if.sv @@
// ----------------------------------------------------------------------------
// hms_item_if
// Input item channel: operation, stamp center and radius, read coordinates.
// ----------------------------------------------------------------------------
interface hms_item_if;
    import hms_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [OP_W-1:0]       operation;
    logic [COORD_IN_W-1:0] center_row;
    logic [COORD_IN_W-1:0] center_col;
    logic [RADIUS_W-1:0]   radius;
    logic [COORD_IN_W-1:0] cell_row;
    logic [COORD_IN_W-1:0] cell_col;

    modport source (
        output valid, operation, center_row, center_col, radius, cell_row, cell_col,
        input  ready
    );

    modport sink (
        input  valid, operation, center_row, center_col, radius, cell_row, cell_col,
        output ready
    );
endinterface

@@ rtl/core/hms_result_if.sv @@
// ----------------------------------------------------------------------------
// hms_result_if
// Result channel: raw height, scaled height, peak and undefined-scale flag.
// ----------------------------------------------------------------------------
interface hms_result_if;
    import hms_pkg::*;

    logic                valid;
    logic                ready;
    logic [HEIGHT_W-1:0] cell_height;
    logic [SCALED_W-1:0] scaled_height;
    logic [HEIGHT_W-1:0] peak_height;
    logic                scale_undefined;

    modport source (
        output valid, cell_height, scaled_height, peak_height, scale_undefined,
        input  ready
    );

    modport sink (
        input  valid, cell_height, scaled_height, peak_height, scale_undefined,
        output ready
    );
endinterface

@@ rtl/core/hms_cfg_if.sv @@
// ----------------------------------------------------------------------------
// hms_cfg_if
// Configuration write channel for the map side register.
// ----------------------------------------------------------------------------
interface hms_cfg_if;
    import hms_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [SIDE_CFG_W-1:0] map_side;

    modport source (
        output valid, map_side,
        input  ready
    );

    modport sink (
        input  valid, map_side,
        output ready
    );
endinterface

@@ rtl/core/hms_ram.sv @@
// ----------------------------------------------------------------------------
// hms_ram
// Generic simple dual port RAM, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module hms_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;
endmodule

@@ rtl/core/hms_square_unit.sv @@
// ----------------------------------------------------------------------------
// hms_square_unit
// Shared squarer for radius and row and column distances.
// ----------------------------------------------------------------------------
module hms_square_unit (
    input  logic [hms_pkg::RADIUS_W-1:0] operand,
    output logic [hms_pkg::SQUARE_W-1:0] square
);
    import hms_pkg::*;

    assign square = SQUARE_W'(operand) * SQUARE_W'(operand);
endmodule

@@ rtl/core/hms_divider.sv @@
// ----------------------------------------------------------------------------
// hms_divider
// Restoring divider, one quotient bit per cycle, for the height scale factor.
// ----------------------------------------------------------------------------
module hms_divider (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [hms_pkg::HEIGHT_W-1:0]  dividend_hi,
    input  logic [hms_pkg::SCALED_W-1:0]  dividend_lo,
    input  logic [hms_pkg::HEIGHT_W-1:0]  divisor,
    output hms_pkg::hms_div_status_t      status,
    output logic [hms_pkg::SCALED_W-1:0]  quotient
);
    import hms_pkg::*;

    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [DIV_CNT_W-1:0] count_reg, count_next;
    logic [HEIGHT_W-1:0]  rem_reg, rem_next;
    logic [SCALED_W-1:0]  lo_reg, lo_next;
    logic [SCALED_W-1:0]  q_reg, q_next;
    logic [HEIGHT_W-1:0]  divisor_reg, divisor_next;
    logic [HEIGHT_W:0]    trial;
    logic [HEIGHT_W:0]    diff;
    logic                 fits;

    // partial remainder stays below the divisor, so one extra bit suffices
    assign trial = {rem_reg, lo_reg[SCALED_W-1]};
    assign diff  = trial - {1'b0, divisor_reg};
    assign fits  = trial >= {1'b0, divisor_reg};

    always_comb
    begin
        busy_next    = busy_reg;
        done_next    = 1'b0;
        count_next   = count_reg;
        rem_next     = rem_reg;
        lo_next      = lo_reg;
        q_next       = q_reg;
        divisor_next = divisor_reg;
        if (start)
        begin
            busy_next    = 1'b1;
            count_next   = DIV_CNT_W'(DIV_STEPS);
            rem_next     = dividend_hi;
            lo_next      = dividend_lo;
            divisor_next = divisor;
            q_next       = '0;
        end
        else if (busy_reg)
        begin
            rem_next   = fits ? diff[HEIGHT_W-1:0] : trial[HEIGHT_W-1:0];
            lo_next    = {lo_reg[SCALED_W-2:0], 1'b0};
            q_next     = {q_reg[SCALED_W-2:0], fits};
            count_next = count_reg - DIV_CNT_W'(1);
            if (count_reg == DIV_CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            count_reg <= '0;
        end
        else
        begin
            busy_reg  <= busy_next;
            done_reg  <= done_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg     <= rem_next;
        lo_reg      <= lo_next;
        q_reg       <= q_next;
        divisor_reg <= divisor_next;
    end

    assign status.busy = busy_reg;
    assign status.done = done_reg;
    assign quotient    = q_reg;
endmodule

@@ rtl/core/height_map_hill_stamper.sv @@
// ----------------------------------------------------------------------------
// height_map_hill_stamper
// Square height map with hill stamping, clearing and scaled cell reads.
// ----------------------------------------------------------------------------
// The block holds a SIDE by SIDE map of 32-bit heights in one RAM and a
// running peak. It works on one item at a time and drops ready while busy.
// A clear zeroes the whole store by writing one entry per cycle, then hands
// over the result. A stamp squares the radius, then for each row of the
// clipped square squares the row distance, and for each visited cell reads
// the RAM, then adds and writes back. A read fetches the cell from the RAM,
// then scales it; the scale division runs only when the peak is nonzero and
// not below the cell, and the divider yields one quotient bit per cycle; a
// read beyond the store skips the RAM access. After reset the block
// first sweeps zeros through the store and accepts no item in that time;
// configuration beats are always taken.
// Results sit in an output register, so the next item is taken while the
// previous result still waits; an item that finishes before that result has
// gone holds in its last cycle until the output register is free.
// ----------------------------------------------------------------------------
module height_map_hill_stamper #(
    parameter int SIDE = 64
) (
    input  logic          clk,
    input  logic          rst_n,
    hms_item_if.sink      item,
    hms_result_if.source  result,
    hms_cfg_if.sink       cfg
);
    import hms_pkg::*;

    localparam int DEPTH   = SIDE * SIDE;
    localparam int ADDR_W  = $clog2(DEPTH);
    localparam int COORD_W = $clog2(SIDE);
    // signed width for clip math: covers center plus radius and the side itself
    localparam int SPAN_W  = ((COORD_W > RADIUS_W + 1) ? COORD_W : RADIUS_W + 1) + 2;

    localparam logic [SPAN_W-1:0]        SIDE_U    = SPAN_W'(SIDE);
    localparam logic signed [SPAN_W-1:0] ONE_S     = SPAN_W'(1);
    localparam logic [ADDR_W-1:0]        SIDE_A    = ADDR_W'(SIDE);
    localparam logic [ADDR_W-1:0]        LAST_ADDR = ADDR_W'(DEPTH - 1);

    // sequencer states
    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_WIPE  = 4'd1;
    localparam logic [3:0] ST_RSQ   = 4'd2;
    localparam logic [3:0] ST_ROW   = 4'd3;
    localparam logic [3:0] ST_RD    = 4'd4;
    localparam logic [3:0] ST_WR    = 4'd5;
    localparam logic [3:0] ST_RADDR = 4'd6;
    localparam logic [3:0] ST_RDATA = 4'd7;
    localparam logic [3:0] ST_SCALE = 4'd8;
    localparam logic [3:0] ST_DIV   = 4'd9;
    localparam logic [3:0] ST_EMIT  = 4'd10;

    // control state
    logic [3:0]            state_reg, state_next;
    logic [ADDR_W-1:0]     wipe_addr_reg, wipe_addr_next;
    logic                  wipe_emit_reg, wipe_emit_next;
    logic [HEIGHT_W-1:0]   peak_reg, peak_next;
    logic [SIDE_CFG_W-1:0] map_side_reg, map_side_next;
    logic                  out_valid_reg, out_valid_next;

    // working payload
    logic [COORD_IN_W-1:0] crow_reg, crow_next;
    logic [COORD_IN_W-1:0] ccol_reg, ccol_next;
    logic [RADIUS_W-1:0]   rad_reg, rad_next;
    logic [COORD_W-1:0]    row_reg, row_next;
    logic [COORD_W-1:0]    col_reg, col_next;
    logic [COORD_W-1:0]    r1_reg, r1_next;
    logic [COORD_W-1:0]    c0_reg, c0_next;
    logic [COORD_W-1:0]    c1_reg, c1_next;
    logic [SQUARE_W-1:0]   rad_sq_reg, rad_sq_next;
    logic [SQUARE_W-1:0]   di_sq_reg, di_sq_next;
    logic [SQUARE_W-1:0]   gain_reg, gain_next;
    logic [ADDR_W-1:0]     addr_reg, addr_next;
    logic [HEIGHT_W-1:0]   height_reg, height_next;
    logic [SCALED_W-1:0]   scaled_reg, scaled_next;

    // output register payload
    logic [HEIGHT_W-1:0]   out_height_reg, out_height_next;
    logic [SCALED_W-1:0]   out_scaled_reg, out_scaled_next;
    logic [HEIGHT_W-1:0]   out_peak_reg, out_peak_next;
    logic                  out_undef_reg, out_undef_next;

    // clip window of an incoming stamp
    logic [SPAN_W-1:0]        side_use;
    logic signed [SPAN_W-1:0] last_s;
    logic signed [SPAN_W-1:0] in_crow_s, in_ccol_s, in_rad_s;
    logic signed [SPAN_W-1:0] lo_row_s, hi_row_s, lo_col_s, hi_col_s;
    logic signed [SPAN_W-1:0] r0_s, r1_s, c0_s, c1_s;
    logic                     window_empty;

    // read item address
    logic                in_store;
    logic [ADDR_W-1:0]   read_addr;

    // shared squarer and distances
    logic [RADIUS_W-1:0]      sq_operand;
    logic [SQUARE_W-1:0]      sq_result;
    logic signed [SPAN_W-1:0] di_s, dj_s;
    logic [SPAN_W-1:0]        di_abs, dj_abs;
    logic [SQUARE_W:0]        dist_sq;
    logic [SQUARE_W:0]        gain_wide;

    // cell update
    logic [HEIGHT_W:0]   sum;
    logic [HEIGHT_W-1:0] cell_new;
    logic [ADDR_W-1:0]   cell_addr;

    // RAM and divider hookup
    logic                ram_wr_en;
    logic [ADDR_W-1:0]   ram_wr_addr;
    logic [HEIGHT_W-1:0] ram_wr_data;
    logic                ram_rd_en;
    logic [ADDR_W-1:0]   ram_rd_addr;
    logic [HEIGHT_W-1:0] ram_rd_data;
    logic                div_start;
    logic [HEIGHT_W+2:0] height_x5;
    logic [HEIGHT_W-1:0] div_hi;
    logic [SCALED_W-1:0] div_lo;
    hms_div_status_t     div_status;
    logic [SCALED_W-1:0] div_quotient;

    logic in_beat;
    logic out_load;

    assign item.ready = (state_reg == ST_IDLE);
    assign in_beat    = item.valid && item.ready;
    assign cfg.ready  = 1'b1;

    // side in use saturates at the store edge
    assign side_use  = (SPAN_W'(map_side_reg) > SIDE_U) ? SIDE_U : SPAN_W'(map_side_reg);
    assign last_s    = $signed(side_use) - ONE_S;
    assign in_crow_s = $signed(SPAN_W'(item.center_row));
    assign in_ccol_s = $signed(SPAN_W'(item.center_col));
    assign in_rad_s  = $signed(SPAN_W'(item.radius));
    assign lo_row_s  = in_crow_s - in_rad_s;
    assign hi_row_s  = in_crow_s + in_rad_s;
    assign lo_col_s  = in_ccol_s - in_rad_s;
    assign hi_col_s  = in_ccol_s + in_rad_s;
    // border row and column zero are never stamped
    assign r0_s = (lo_row_s < ONE_S) ? ONE_S : lo_row_s;
    assign c0_s = (lo_col_s < ONE_S) ? ONE_S : lo_col_s;
    assign r1_s = (hi_row_s > last_s) ? last_s : hi_row_s;
    assign c1_s = (hi_col_s > last_s) ? last_s : hi_col_s;
    assign window_empty = (r0_s > r1_s) || (c0_s > c1_s);

    // reads beyond the store answer zero
    assign in_store  = (SPAN_W'(item.cell_row) < SIDE_U) && (SPAN_W'(item.cell_col) < SIDE_U);
    assign read_addr = ADDR_W'(item.cell_row) * SIDE_A + ADDR_W'(item.cell_col);

    // row and column distances, bounded by the radius inside the window
    assign di_s   = $signed(SPAN_W'(crow_reg)) - $signed(SPAN_W'(row_reg));
    assign dj_s   = $signed(SPAN_W'(ccol_reg)) - $signed(SPAN_W'(col_reg));
    assign di_abs = (di_s < 0) ? SPAN_W'(-di_s) : SPAN_W'(di_s);
    assign dj_abs = (dj_s < 0) ? SPAN_W'(-dj_s) : SPAN_W'(dj_s);

    always_comb
    begin
        case (state_reg)
            ST_RSQ:  sq_operand = rad_reg;
            ST_ROW:  sq_operand = di_abs[RADIUS_W-1:0];
            ST_RD:   sq_operand = dj_abs[RADIUS_W-1:0];
            default: sq_operand = '0;
        endcase
    end

    hms_square_unit u_square (
        .operand (sq_operand),
        .square  (sq_result)
    );

    // gain is r^2 - d^2 where positive
    assign dist_sq   = {1'b0, di_sq_reg} + {1'b0, sq_result};
    assign gain_wide = {1'b0, rad_sq_reg} - dist_sq;
    assign cell_addr = ADDR_W'(row_reg) * SIDE_A + ADDR_W'(col_reg);

    // saturating accumulate of the fetched cell
    assign sum      = {1'b0, ram_rd_data} + (HEIGHT_W + 1)'(gain_reg);
    assign cell_new = sum[HEIGHT_W] ? MAX_HEIGHT : sum[HEIGHT_W-1:0];

    // 20 * 256 * h = (5 * h) << 10, split at the quotient width
    assign height_x5 = {3'b000, height_reg} + {1'b0, height_reg, 2'b00};
    assign div_hi    = height_x5[HEIGHT_W+2:3];
    assign div_lo    = {height_x5[2:0], 10'b0};

    assign out_load = (state_reg == ST_EMIT) && (!out_valid_reg || result.ready);

    assign map_side_next = (cfg.valid && cfg.ready) ? cfg.map_side : map_side_reg;

    always_comb
    begin
        state_next     = state_reg;
        wipe_addr_next = wipe_addr_reg;
        wipe_emit_next = wipe_emit_reg;
        peak_next      = peak_reg;
        crow_next      = crow_reg;
        ccol_next      = ccol_reg;
        rad_next       = rad_reg;
        row_next       = row_reg;
        col_next       = col_reg;
        r1_next        = r1_reg;
        c0_next        = c0_reg;
        c1_next        = c1_reg;
        rad_sq_next    = rad_sq_reg;
        di_sq_next     = di_sq_reg;
        gain_next      = gain_reg;
        addr_next      = addr_reg;
        height_next    = height_reg;
        scaled_next    = scaled_reg;
        ram_wr_en      = 1'b0;
        ram_wr_addr    = addr_reg;
        ram_wr_data    = cell_new;
        ram_rd_en      = 1'b0;
        ram_rd_addr    = addr_reg;
        div_start      = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_beat)
                begin
                    height_next = '0;
                    scaled_next = '0;
                    crow_next   = item.center_row;
                    ccol_next   = item.center_col;
                    rad_next    = item.radius;
                    row_next    = r0_s[COORD_W-1:0];
                    r1_next     = r1_s[COORD_W-1:0];
                    c0_next     = c0_s[COORD_W-1:0];
                    c1_next     = c1_s[COORD_W-1:0];
                    addr_next   = read_addr;
                    case (item.operation)
                        OP_CLEAR:
                        begin
                            peak_next      = '0;
                            wipe_addr_next = '0;
                            wipe_emit_next = 1'b1;
                            state_next     = ST_WIPE;
                        end
                        OP_STAMP:
                        begin
                            state_next = window_empty ? ST_EMIT : ST_RSQ;
                        end
                        OP_READ:
                        begin
                            state_next = in_store ? ST_RADDR : ST_SCALE;
                        end
                        default:
                        begin
                            // unused code: no change, empty result
                            state_next = ST_EMIT;
                        end
                    endcase
                end
            end
            ST_WIPE:
            begin
                ram_wr_en      = 1'b1;
                ram_wr_addr    = wipe_addr_reg;
                ram_wr_data    = '0;
                wipe_addr_next = wipe_addr_reg + ADDR_W'(1);
                if (wipe_addr_reg == LAST_ADDR)
                begin
                    wipe_addr_next = '0;
                    state_next     = wipe_emit_reg ? ST_EMIT : ST_IDLE;
                end
            end
            ST_RSQ:
            begin
                rad_sq_next = sq_result;
                state_next  = ST_ROW;
            end
            ST_ROW:
            begin
                di_sq_next = sq_result;
                col_next   = c0_reg;
                state_next = ST_RD;
            end
            ST_RD:
            begin
                gain_next   = gain_wide[SQUARE_W] ? '0 : gain_wide[SQUARE_W-1:0];
                addr_next   = cell_addr;
                ram_rd_en   = 1'b1;
                ram_rd_addr = cell_addr;
                state_next  = ST_WR;
            end
            ST_WR:
            begin
                ram_wr_en = 1'b1;
                // every visited cell can raise the peak, gain or not
                if (cell_new > peak_reg)
                begin
                    peak_next = cell_new;
                end
                if (col_reg == c1_reg)
                begin
                    if (row_reg == r1_reg)
                    begin
                        state_next = ST_EMIT;
                    end
                    else
                    begin
                        row_next   = row_reg + COORD_W'(1);
                        state_next = ST_ROW;
                    end
                end
                else
                begin
                    col_next   = col_reg + COORD_W'(1);
                    state_next = ST_RD;
                end
            end
            ST_RADDR:
            begin
                ram_rd_en  = 1'b1;
                state_next = ST_RDATA;
            end
            ST_RDATA:
            begin
                height_next = ram_rd_data;
                state_next  = ST_SCALE;
            end
            ST_SCALE:
            begin
                if (peak_reg == '0)
                begin
                    scaled_next = '0;
                    state_next  = ST_EMIT;
                end
                else if (height_reg > peak_reg)
                begin
                    scaled_next = SCALE_TOP;
                    state_next  = ST_EMIT;
                end
                else
                begin
                    div_start  = 1'b1;
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                if (div_status.done)
                begin
                    scaled_next = div_quotient;
                    state_next  = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (out_load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // output register: loads on finish, drains on the result beat
    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_height_next = out_height_reg;
        out_scaled_next = out_scaled_reg;
        out_peak_next   = out_peak_reg;
        out_undef_next  = out_undef_reg;
        if (out_load)
        begin
            out_valid_next  = 1'b1;
            out_height_next = height_reg;
            out_scaled_next = scaled_reg;
            out_peak_next   = peak_reg;
            out_undef_next  = (peak_reg == '0);
        end
        else if (result.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    hms_ram #(
        .WIDTH (HEIGHT_W),
        .DEPTH (DEPTH)
    ) u_store (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    hms_divider u_divider (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (div_start),
        .dividend_hi (div_hi),
        .dividend_lo (div_lo),
        .divisor     (peak_reg),
        .status      (div_status),
        .quotient    (div_quotient)
    );

    // reset starts with a zero sweep of the store, no result afterwards
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_WIPE;
            wipe_addr_reg <= '0;
            wipe_emit_reg <= 1'b0;
            peak_reg      <= '0;
            map_side_reg  <= SIDE_CFG_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            wipe_addr_reg <= wipe_addr_next;
            wipe_emit_reg <= wipe_emit_next;
            peak_reg      <= peak_next;
            map_side_reg  <= map_side_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        crow_reg       <= crow_next;
        ccol_reg       <= ccol_next;
        rad_reg        <= rad_next;
        row_reg        <= row_next;
        col_reg        <= col_next;
        r1_reg         <= r1_next;
        c0_reg         <= c0_next;
        c1_reg         <= c1_next;
        rad_sq_reg     <= rad_sq_next;
        di_sq_reg      <= di_sq_next;
        gain_reg       <= gain_next;
        addr_reg       <= addr_next;
        height_reg     <= height_next;
        scaled_reg     <= scaled_next;
        out_height_reg <= out_height_next;
        out_scaled_reg <= out_scaled_next;
        out_peak_reg   <= out_peak_next;
        out_undef_reg  <= out_undef_next;
    end

    assign result.valid           = out_valid_reg;
    assign result.cell_height     = out_height_reg;
    assign result.scaled_height   = out_scaled_reg;
    assign result.peak_height     = out_peak_reg;
    assign result.scale_undefined = out_undef_reg;
endmodule

@@ verif/tb_height_map_hill_stamper.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_height_map_hill_stamper
// Self-checking bench for the hill stamper. Items are predicted on acceptance
// against a local copy of the map and peak, results are compared field by
// field in order, with random gaps and stalls on both channels.
// ----------------------------------------------------------------------------
module tb_height_map_hill_stamper;
    import hms_pkg::*;

    // map edge of the instance, store holds MAP_SIDE_MAX squared cells
    localparam int MAP_SIDE_MAX = 64;
    localparam int STORE_DEPTH  = MAP_SIDE_MAX * MAP_SIDE_MAX;
    // q8 scale factor, 20 times 256
    localparam longint SCALE_NUM = 20 * 256;
    // opcode the block leaves unused
    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
    // far above any mix the stimulus can produce, long stalls included
    localparam int CYCLE_LIMIT      = 5_000_000;
    localparam int LONG_HOLD_CYCLES = 400;
    localparam int DRAIN_TAIL       = 64;

    typedef struct packed {
        logic [OP_W-1:0]       operation;
        logic [COORD_IN_W-1:0] center_row;
        logic [COORD_IN_W-1:0] center_col;
        logic [RADIUS_W-1:0]   radius;
        logic [COORD_IN_W-1:0] cell_row;
        logic [COORD_IN_W-1:0] cell_col;
    } map_item_t;

    typedef struct packed {
        logic [HEIGHT_W-1:0] cell_height;
        logic [SCALED_W-1:0] scaled_height;
        logic [HEIGHT_W-1:0] peak_height;
        logic                scale_undefined;
    } hill_result_t;

    logic clk = 1'b0;
    logic rst_n;

    hms_item_if   item_ch ();
    hms_result_if result_ch ();
    hms_cfg_if    cfg_ch ();

    height_map_hill_stamper #(
        .SIDE (MAP_SIDE_MAX)
    ) uut (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item_ch),
        .result (result_ch),
        .cfg    (cfg_ch)
    );

    // local copy of the block state
    logic [HEIGHT_W-1:0]   height_map [0:STORE_DEPTH-1];
    logic [HEIGHT_W-1:0]   peak_now;
    logic [SIDE_CFG_W-1:0] side_setting;

    // results still owed by the block, oldest first
    hill_result_t pending_results [$];

    int error_count  = 0;
    int result_count = 0;
    int cycle_count  = 0;

    // idling controls: source side is used only by the main thread,
    // sink side and the hold request are written with nba from it
    bit src_idle_on    = 1'b1;
    bit sink_stalls_on = 1'b1;
    int holds_asked    = 0;

    // last stamp center, reads cluster around it to hit nonzero cells
    int recent_row = 32;
    int recent_col = 32;

    // 12 ns clock
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count = cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    // side in use saturates at the store edge
    function automatic int side_in_use();
        return (side_setting > MAP_SIDE_MAX) ? MAP_SIDE_MAX : int'(side_setting);
    endfunction

    // gap length: mostly short, now and then long
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 70)
            return $urandom_range(1, 3);
        else if (roll < 95)
            return $urandom_range(4, 16);
        return $urandom_range(30, 120);
    endfunction

    // update the map copy for one beat and return what the block must answer
    function automatic hill_result_t apply_item(input map_item_t it);
        hill_result_t res;
        longint       rad, row_lo, row_hi, col_lo, col_hi, di, dj, gain, sum;
        int           idx;
        logic [63:0]  ratio;
        res = '0;
        case (it.operation)
            OP_CLEAR:
            begin
                // whole store, whatever side is in use
                foreach (height_map[k])
                    height_map[k] = '0;
                peak_now = '0;
            end
            OP_STAMP:
            begin
                rad    = longint'(it.radius);
                row_lo = longint'(it.center_row) - rad;
                row_hi = longint'(it.center_row) + rad;
                col_lo = longint'(it.center_col) - rad;
                col_hi = longint'(it.center_col) + rad;
                // clip to rows and columns 1 .. side-1
                if (row_lo < 1) row_lo = 1;
                if (col_lo < 1) col_lo = 1;
                if (row_hi > side_in_use() - 1) row_hi = side_in_use() - 1;
                if (col_hi > side_in_use() - 1) col_hi = side_in_use() - 1;
                for (longint i = row_lo; i <= row_hi; i++)
                begin
                    for (longint j = col_lo; j <= col_hi; j++)
                    begin
                        di   = longint'(it.center_row) - i;
                        dj   = longint'(it.center_col) - j;
                        gain = rad * rad - (di * di + dj * dj);
                        idx  = int'(i) * MAP_SIDE_MAX + int'(j);
                        if (gain > 0)
                        begin
                            sum = longint'(height_map[idx]) + gain;
                            height_map[idx] = (sum > longint'(MAX_HEIGHT)) ?
                                              MAX_HEIGHT : sum[HEIGHT_W-1:0];
                        end
                        // peak follows every visited cell, gain or not
                        if (height_map[idx] > peak_now)
                            peak_now = height_map[idx];
                    end
                end
            end
            OP_READ:
            begin
                if (it.cell_row < MAP_SIDE_MAX && it.cell_col < MAP_SIDE_MAX)
                    res.cell_height =
                        height_map[int'(it.cell_row) * MAP_SIDE_MAX + int'(it.cell_col)];
                if (peak_now != '0)
                begin
                    ratio = ({32'd0, res.cell_height} * 64'(SCALE_NUM)) / {32'd0, peak_now};
                    res.scaled_height = (ratio > 64'(SCALE_TOP)) ?
                                        SCALE_TOP : ratio[SCALED_W-1:0];
                end
            end
            default:
            begin
                // unused code leaves everything alone
            end
        endcase
        res.peak_height     = peak_now;
        res.scale_undefined = (peak_now == '0);
        return res;
    endfunction

    function automatic map_item_t item_of(input logic [OP_W-1:0] op,
                                          input int crow, input int ccol, input int rad,
                                          input int rrow, input int rcol);
        map_item_t it;
        it.operation  = op;
        it.center_row = crow[COORD_IN_W-1:0];
        it.center_col = ccol[COORD_IN_W-1:0];
        it.radius     = rad[RADIUS_W-1:0];
        it.cell_row   = rrow[COORD_IN_W-1:0];
        it.cell_col   = rcol[COORD_IN_W-1:0];
        return it;
    endfunction

    // mostly reads, most of them near the last stamp, with stamps, clears and
    // unused codes mixed in; unused fields carry random bits
    function automatic map_item_t make_random_item();
        map_item_t it;
        int        roll, span, v;
        it = item_of(OP_READ, $urandom_range(0, 63), $urandom_range(0, 63),
                     $urandom_range(0, 255), $urandom_range(0, 63), $urandom_range(0, 63));
        span = side_in_use();
        roll = $urandom_range(0, 99);
        if (roll < 4)
            it.operation = OP_CLEAR;
        else if (roll < 34)
        begin
            it.operation = OP_STAMP;
            // center inside the side in use most of the time
            if (span > 0 && $urandom_range(0, 3) != 0)
            begin
                it.center_row = COORD_IN_W'($urandom_range(0, span - 1));
                it.center_col = COORD_IN_W'($urandom_range(0, span - 1));
            end
            // small hills keep the run short, a few cover the whole map
            roll = $urandom_range(0, 99);
            if (roll < 75)
                it.radius = RADIUS_W'($urandom_range(0, 5));
            else if (roll < 92)
                it.radius = RADIUS_W'($urandom_range(6, 14));
            else if (roll < 96)
                it.radius = RADIUS_W'($urandom_range(128, 255));
            recent_row = it.center_row;
            recent_col = it.center_col;
        end
        else if (roll < 40)
            it.operation = OP_UNUSED;
        else if ($urandom_range(0, 9) < 7)
        begin
            // read close to the last hill
            v = recent_row + $urandom_range(0, 6) - 3;
            it.cell_row = COORD_IN_W'((v < 0) ? 0 : (v > 63) ? 63 : v);
            v = recent_col + $urandom_range(0, 6) - 3;
            it.cell_col = COORD_IN_W'((v < 0) ? 0 : (v > 63) ? 63 : v);
        end
        return it;
    endfunction

    // one line per mismatch, and count it
    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("[%0t] result %0d: %s got 0x%0h expected 0x%0h",
                 $time, result_count, what, got, want);
        error_count = error_count + 1;
    endtask

    // offer one beat, leave valid high on return so back-to-back beats
    // need no second assignment in the same step
    task automatic send_item(input map_item_t it);
        int           gap;
        hill_result_t owed;
        gap = 0;
        if (src_idle_on && $urandom_range(0, 99) < 30)
            gap = pick_gap();
        if (gap > 0)
        begin
            item_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item_ch.operation  <= it.operation;
        item_ch.center_row <= it.center_row;
        item_ch.center_col <= it.center_col;
        item_ch.radius     <= it.radius;
        item_ch.cell_row   <= it.cell_row;
        item_ch.cell_col   <= it.cell_col;
        item_ch.valid      <= 1'b1;
        do
            @(posedge clk);
        while (!item_ch.ready);
        // accepted at this edge
        owed = apply_item(it);
        pending_results.insert(pending_results.size(), owed);
    endtask

    // drop valid and wait until every owed result is back; queue is checked
    // on the falling edge so the check never races the result monitor
    task automatic wait_drained();
        item_ch.valid <= 1'b0;
        @(negedge clk);
        while (pending_results.size() != 0)
            @(negedge clk);
        @(posedge clk);
    endtask

    // single register write, only called with the block idle
    task automatic write_map_side(input logic [SIDE_CFG_W-1:0] value);
        cfg_ch.map_side <= value;
        cfg_ch.valid    <= 1'b1;
        do
            @(posedge clk);
        while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
        side_setting = value;
    endtask

    // field extremes, every opcode, clipping at the map edges, empty peak
    task automatic test_directed_extremes();
        send_item(item_of(OP_READ,   0,  0,   0,  0,  0));  // empty map, no peak
        send_item(item_of(OP_UNUSED, 0,  0,   0,  0,  0));  // unused code on empty map
        send_item(item_of(OP_STAMP, 32, 32,   5,  0,  0));
        send_item(item_of(OP_READ,  63, 63, 255, 32, 32));  // hill top, full scale
        send_item(item_of(OP_READ,   0,  0,   0, 32, 35));  // hill side
        send_item(item_of(OP_STAMP, 32, 32,   0, 63, 63));  // zero radius adds nothing
        send_item(item_of(OP_STAMP,  0,  0,   3,  0,  0));  // clipped at top left
        send_item(item_of(OP_READ,   0,  0,   0,  0,  0));  // row zero never stamped
        send_item(item_of(OP_READ,   0,  0,   0,  1,  1));
        send_item(item_of(OP_STAMP, 63, 63, 255,  0,  0));  // whole map from far corner
        send_item(item_of(OP_READ,   0,  0,   0, 63, 63));
        send_item(item_of(OP_READ,   0,  0,   0,  0, 63));
        send_item(item_of(OP_STAMP,  0, 63, 255, 63,  0));
        send_item(item_of(OP_UNUSED, 63, 63, 255, 63, 63)); // all ones, no change
        send_item(item_of(OP_READ,  63, 63, 255, 63,  0));
        send_item(item_of(OP_READ,   0,  0,   0, 32, 32));
        send_item(item_of(OP_CLEAR, 63, 63, 255, 63, 63));
        send_item(item_of(OP_READ,   0,  0,   0, 63, 63));  // cleared, no peak again
        send_item(item_of(OP_STAMP, 63,  0,   1,  0,  0));  // only zero gains, peak stays 0
        send_item(item_of(OP_STAMP, 10, 20,   2,  0,  0));
        send_item(item_of(OP_READ,   0,  0,   0, 10, 20));
        send_item(item_of(OP_READ,   0,  0,   0,  9, 20));
        wait_drained();
    endtask

    // random phases, each under its own side setting, extremes included
    task automatic test_random_phases();
        logic [SIDE_CFG_W-1:0] side_plan [0:9];
        side_plan = '{7'd64, 7'd2, 7'd127, 7'd0, 7'd13, 7'd1, 7'd100, 7'd3, 7'd40, 7'd64};
        side_plan[8] = SIDE_CFG_W'($urandom_range(0, 127));
        for (int p = 0; p < 10; p++)
        begin
            wait_drained();
            write_map_side(side_plan[p]);
            // one phase runs with no idling on either side
            if (p == 4)
            begin
                src_idle_on = 1'b0;
                sink_stalls_on <= 1'b0;
            end
            else
            begin
                src_idle_on = 1'b1;
                sink_stalls_on <= 1'b1;
            end
            if ($urandom_range(0, 2) == 0)
                send_item(item_of(OP_CLEAR, $urandom_range(0, 63), $urandom_range(0, 63),
                                  $urandom_range(0, 255), $urandom_range(0, 63),
                                  $urandom_range(0, 63)));
            for (int n = 0; n < 55; n++)
                send_item(make_random_item());
        end
        src_idle_on = 1'b1;
        sink_stalls_on <= 1'b1;
        wait_drained();
    endtask

    // receiver holds off for a long stretch while beats keep coming, so the
    // output register and the working slot fill and ready drops
    task automatic test_stall_fill();
        holds_asked <= holds_asked + 1;
        src_idle_on = 1'b0;
        send_item(item_of(OP_STAMP, 20, 20, 3, 0, 0));
        for (int n = 0; n < 7; n++)
            send_item(item_of(OP_READ, 0, 0, 0, 20, 17 + n));
        src_idle_on = 1'b1;
        wait_drained();
    endtask

    // sender stops until everything owed has come back, then resumes
    task automatic test_drain_pause();
        for (int n = 0; n < 6; n++)
            send_item(make_random_item());
        wait_drained();
        for (int n = 0; n < 6; n++)
            send_item(make_random_item());
        wait_drained();
    endtask

    // result ready: random stalls, plus a long hold on request
    initial
    begin : result_sink
        int stall_left;
        int holds_served;
        stall_left   = 0;
        holds_served = 0;
        result_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (holds_asked != holds_served)
            begin
                holds_served = holds_asked;
                stall_left   = LONG_HOLD_CYCLES;
            end
            else if (stall_left == 0 && sink_stalls_on && $urandom_range(0, 99) < 25)
                stall_left = pick_gap();
            if (stall_left > 0)
            begin
                result_ch.ready <= 1'b0;
                stall_left = stall_left - 1;
            end
            else
                result_ch.ready <= 1'b1;
        end
    end

    // compare every accepted result beat with the oldest owed one
    always @(posedge clk)
    begin : result_monitor
        hill_result_t want;
        if (rst_n && result_ch.valid && result_ch.ready)
        begin
            result_count = result_count + 1;
            if (pending_results.size() == 0)
                report_mismatch("beat with nothing owed, cell_height",
                                result_ch.cell_height, '0);
            else
            begin
                want = pending_results.pop_front();
                if (result_ch.cell_height !== want.cell_height)
                    report_mismatch("cell_height", result_ch.cell_height, want.cell_height);
                if (result_ch.scaled_height !== want.scaled_height)
                    report_mismatch("scaled_height", result_ch.scaled_height,
                                    want.scaled_height);
                if (result_ch.peak_height !== want.peak_height)
                    report_mismatch("peak_height", result_ch.peak_height, want.peak_height);
                if (result_ch.scale_undefined !== want.scale_undefined)
                    report_mismatch("scale_undefined", result_ch.scale_undefined,
                                    want.scale_undefined);
            end
        end
    end

    // main sequence
    initial
    begin : run
        rst_n              <= 1'b0;
        item_ch.valid      <= 1'b0;
        item_ch.operation  <= OP_READ;
        item_ch.center_row <= '0;
        item_ch.center_col <= '0;
        item_ch.radius     <= '0;
        item_ch.cell_row   <= '0;
        item_ch.cell_col   <= '0;
        cfg_ch.valid       <= 1'b0;
        cfg_ch.map_side    <= SIDE_CFG_RESET;
        // state after reset
        foreach (height_map[k])
            height_map[k] = '0;
        peak_now     = '0;
        side_setting = SIDE_CFG_RESET;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        // block sweeps its store first, send_item simply waits for ready
        test_directed_extremes();
        test_random_phases();
        test_stall_fill();
        test_drain_pause();
        wait_drained();
        // catch any stray beat after the last owed one
        repeat (DRAIN_TAIL) @(posedge clk);
        if (error_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
